// ----- sv/vfsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the viewport follow unit.
// Used by the controller, the datapath and the per-axis lane; depends on nothing.
package vfsc_pkg;

   // Field and register widths.
   localparam int COORD_W     = 32;
   localparam int SIZE_W      = 31;
   localparam int GAIN_W      = 16;
   localparam int OPCODE_W    = 3;
   localparam int CSR_INDEX_W = 3;

   // Internal arithmetic widths.
   localparam int WIDE_W      = 36;
   localparam int ERR_W       = 34;
   localparam int PROD_W      = ERR_W + GAIN_W + 1;
   localparam int SPRING_W    = COORD_W + GAIN_W + 1;
   localparam int ROUND_SHIFT = 16;
   localparam int STEP_W      = PROD_W - ROUND_SHIFT;

   // Fixed-point settings.
   localparam int FRAC_BITS      = 8;
   localparam int FORCE_DEADBAND = 256;
   localparam int REACH_DIST     = 5;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (ROUND_SHIFT - 1);
   localparam logic [ERR_W:0]           REACH_LIMIT = (ERR_W + 1)'(REACH_DIST) << FRAC_BITS;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_FOLLOW   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ATTACH   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_RECENTRE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_JUMP     = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUND_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUND_TOP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUND_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUND_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_WIDTH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_HEIGHT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLLOW_GAIN  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRING_RECIP = 3'd7;

   // Configuration reset values.
   localparam logic [SIZE_W-1:0] VIEW_WIDTH_RESET  = 31'd163840;
   localparam logic [SIZE_W-1:0] VIEW_HEIGHT_RESET = 31'd122880;
   localparam logic [GAIN_W-1:0] FOLLOW_GAIN_RESET = 16'd6554;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_aim;
      logic jump;
      logic attach;
      logic aim_hi;
      logic aim_lo;
      logic err;
      logic mul_step;
      logic force_sum;
      logic mul_spring;
      logic move;
      logic clamp;
      logic reach;
      logic publish;
   } vfsc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic spring_on;
   } vfsc_status_type;

   // Saturate a wide signed value to the signed coordinate range.
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [WIDE_W-1:0] value
   );
      logic [WIDE_W-COORD_W:0]   top_bits;
      logic signed [COORD_W-1:0] result;
      top_bits = value[WIDE_W-1:COORD_W-1];
      if ((&top_bits) || !(|top_bits)) begin
         result = value[COORD_W-1:0];
      end else if (value[WIDE_W-1]) begin
         result = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return result;
   endfunction

   // Sign-extend a coordinate to the wide working width.
   function automatic logic signed [WIDE_W-1:0] sext_coord(
      input logic signed [COORD_W-1:0] value
   );
      return {{(WIDE_W-COORD_W){value[COORD_W-1]}}, value};
   endfunction

   // Zero-extend a size to the wide working width.
   function automatic logic signed [WIDE_W-1:0] zext_size(input logic [SIZE_W-1:0] value);
      return {{(WIDE_W-SIZE_W){1'b0}}, value};
   endfunction

endpackage

// ----- sv/vfsc_axis.sv -----
`timescale 1ns / 1ps
// One axis of the viewport datapath: origin, aim and force registers with the
// clamp, proportional step and spring arithmetic. Depends on vfsc_pkg.
module vfsc_axis (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vfsc_pkg::vfsc_cmd_type               cmd,
   input  logic                                 bounded,
   input  logic                                 spring_on,
   input  logic signed [vfsc_pkg::COORD_W-1:0]  target,
   input  logic signed [vfsc_pkg::COORD_W-1:0]  lo,
   input  logic [vfsc_pkg::SIZE_W-1:0]          size,
   input  logic [vfsc_pkg::SIZE_W-1:0]          vsize,
   input  logic [vfsc_pkg::GAIN_W-1:0]          gain,
   input  logic [vfsc_pkg::GAIN_W-1:0]          recip,
   output logic signed [vfsc_pkg::COORD_W-1:0]  pos,
   output logic [vfsc_pkg::ERR_W-1:0]           aim_dist
);
   import vfsc_pkg::*;

   localparam logic signed [COORD_W-1:0] DB_POS = COORD_W'(FORCE_DEADBAND);
   localparam logic signed [COORD_W-1:0] DB_NEG = -DB_POS;

   // State and working registers.
   logic signed [COORD_W-1:0] pos_ff, pos_in;
   logic signed [COORD_W-1:0] aim_ff, aim_in;
   logic signed [COORD_W-1:0] force_ff, force_in;
   logic signed [COORD_W-1:0] nf_ff, nf_in;
   logic signed [WIDE_W-1:0]  tmp_ff, tmp_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   // Extended operands.
   logic signed [WIDE_W-1:0] lo_w, size_w, vsize_w, half_w, centre_w;
   logic signed [WIDE_W-1:0] pos_w, aim_w, force_w, target_w;
   logic signed [WIDE_W-1:0] hi_w, amax_w, amin_w, pmax_w;
   logic signed [WIDE_W-1:0] aim_low_w, aim_fit_w, err_w, diff_w, step_w, clamp_w;
   logic signed [ERR_W-1:0]  err_op;
   logic signed [GAIN_W:0]   gain_op, recip_op;
   logic signed [PROD_W-1:0] prod_step, prod_rnd;
   logic signed [SPRING_W-1:0] prod_spring;
   logic signed [STEP_W-1:0] step_v;
   logic signed [COORD_W-1:0] nf_round, nf_kept;

   assign lo_w     = sext_coord(lo);
   assign size_w   = zext_size(size);
   assign vsize_w  = zext_size(vsize);
   assign half_w   = zext_size(vsize >> 1);
   assign centre_w = lo_w + zext_size(size >> 1);
   assign pos_w    = sext_coord(pos_ff);
   assign aim_w    = sext_coord(aim_ff);
   assign force_w  = sext_coord(force_ff);
   assign target_w = sext_coord(target);

   // Bounds derived from the configuration.
   assign hi_w   = lo_w + size_w;
   assign amax_w = hi_w - half_w;
   assign amin_w = lo_w + half_w;
   assign pmax_w = hi_w - vsize_w;

   // Second half of the aim clamp, with recentring when the view is wider.
   assign aim_low_w = (tmp_ff < amin_w) ? amin_w : tmp_ff;
   assign aim_fit_w = (vsize > size) ? centre_w : aim_low_w;

   // Position error toward the aim centre.
   assign err_w = aim_w - pos_w - half_w;

   // Shared rounding of the registered product, ties toward plus infinity.
   assign err_op      = tmp_ff[ERR_W-1:0];
   assign gain_op     = {1'b0, gain};
   assign recip_op    = {1'b0, recip};
   assign prod_step   = PROD_W'(err_op) * PROD_W'(gain_op);
   assign prod_spring = SPRING_W'(nf_ff) * SPRING_W'(recip_op);
   assign prod_rnd    = prod_ff + ROUND_HALF;
   assign step_v      = prod_rnd[PROD_W-1:ROUND_SHIFT];
   assign step_w      = {{(WIDE_W-STEP_W){step_v[STEP_W-1]}}, step_v};

   // A rounded spring force always fits the coordinate range.
   assign nf_round = step_v[COORD_W-1:0];
   assign nf_kept  = ((nf_round > DB_NEG) && (nf_round < DB_POS)) ? '0 : nf_round;

   // Origin clamp inside the area.
   assign clamp_w = (pos_w < lo_w) ? lo_w : ((pos_w > pmax_w) ? pmax_w : pos_w);

   // Distance from the aim on this axis.
   assign diff_w   = pos_w - aim_w + half_w;
   assign aim_dist = diff_w[WIDE_W-1] ? ERR_W'(-diff_w) : diff_w[ERR_W-1:0];
   assign pos      = pos_ff;

   // Next-state selection driven by the controller's commands.
   always_comb begin
      pos_in   = pos_ff;
      aim_in   = aim_ff;
      force_in = force_ff;
      nf_in    = nf_ff;
      tmp_in   = tmp_ff;
      prod_in  = prod_ff;
      if (cmd.load_aim) begin
         aim_in = target;
      end
      if (cmd.jump) begin
         pos_in   = sat_coord(target_w - half_w);
         force_in = '0;
      end
      if (cmd.aim_hi) begin
         tmp_in = (aim_w > amax_w) ? amax_w : aim_w;
      end
      if (cmd.aim_lo && bounded) begin
         aim_in = sat_coord(aim_fit_w);
      end
      if (cmd.err) begin
         tmp_in = err_w;
      end
      if (cmd.mul_step) begin
         prod_in = prod_step;
      end
      if (cmd.force_sum) begin
         nf_in = sat_coord(force_w + step_w);
      end
      if (cmd.mul_spring) begin
         prod_in = {{(PROD_W-SPRING_W){prod_spring[SPRING_W-1]}}, prod_spring};
      end
      if (cmd.move) begin
         if (spring_on) begin
            force_in = nf_kept;
            pos_in   = sat_coord(pos_w + sext_coord(nf_kept));
         end else begin
            pos_in = sat_coord(pos_w + step_w);
         end
      end
      if (cmd.clamp && bounded && (vsize < size)) begin
         pos_in = sat_coord(clamp_w);
      end
   end

   // Architectural state resets to zero; working registers need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         aim_ff   <= '0;
         force_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         aim_ff   <= aim_in;
         force_ff <= force_in;
      end
   end

   always_ff @(posedge clock) begin
      nf_ff   <= nf_in;
      tmp_ff  <= tmp_in;
      prod_ff <= prod_in;
   end

endmodule

// ----- sv/vfsc_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: configuration registers, the two axis lanes, the reached flag and
// the result register. Depends on vfsc_pkg and vfsc_axis.
module vfsc_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [vfsc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [vfsc_pkg::COORD_W-1:0]            csr_wdata,
   input  logic signed [vfsc_pkg::COORD_W-1:0]     req_target_x,
   input  logic signed [vfsc_pkg::COORD_W-1:0]     req_target_y,
   input  vfsc_pkg::vfsc_cmd_type                  cmd,
   output vfsc_pkg::vfsc_status_type               status,
   output logic signed [vfsc_pkg::COORD_W-1:0]     rsp_view_x,
   output logic signed [vfsc_pkg::COORD_W-1:0]     rsp_view_y,
   output logic                                    rsp_reached
);
   import vfsc_pkg::*;

   // Configuration registers.
   logic signed [COORD_W-1:0] bound_left_ff, bound_top_ff;
   logic [SIZE_W-1:0]         bound_width_ff, bound_height_ff;
   logic [SIZE_W-1:0]         view_width_ff, view_height_ff;
   logic [GAIN_W-1:0]         follow_gain_ff, spring_recip_ff;

   logic                      reached_ff, reached_in;
   logic signed [COORD_W-1:0] view_x_ff, view_y_ff;
   logic                      rsp_reached_ff;

   logic                      bounded;
   logic                      spring_on;
   logic signed [COORD_W-1:0] pos_x, pos_y;
   logic [ERR_W-1:0]          dist_x, dist_y;
   logic [ERR_W:0]            dist_sum;

   assign bounded          = (|bound_width_ff) || (|bound_height_ff);
   assign spring_on        = |spring_recip_ff;
   assign status.spring_on = spring_on;

   // Register writes; each register takes the low bits of the write data.
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_left_ff   <= '0;
         bound_top_ff    <= '0;
         bound_width_ff  <= '0;
         bound_height_ff <= '0;
         view_width_ff   <= VIEW_WIDTH_RESET;
         view_height_ff  <= VIEW_HEIGHT_RESET;
         follow_gain_ff  <= FOLLOW_GAIN_RESET;
         spring_recip_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BOUND_LEFT:   bound_left_ff   <= csr_wdata;
            CSR_BOUND_TOP:    bound_top_ff    <= csr_wdata;
            CSR_BOUND_WIDTH:  bound_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_BOUND_HEIGHT: bound_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_VIEW_WIDTH:   view_width_ff   <= csr_wdata[SIZE_W-1:0];
            CSR_VIEW_HEIGHT:  view_height_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_FOLLOW_GAIN:  follow_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_SPRING_RECIP: spring_recip_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Horizontal lane.
   vfsc_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .bounded   (bounded),
      .spring_on (spring_on),
      .target    (req_target_x),
      .lo        (bound_left_ff),
      .size      (bound_width_ff),
      .vsize     (view_width_ff),
      .gain      (follow_gain_ff),
      .recip     (spring_recip_ff),
      .pos       (pos_x),
      .aim_dist  (dist_x)
   );

   // Vertical lane.
   vfsc_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .bounded   (bounded),
      .spring_on (spring_on),
      .target    (req_target_y),
      .lo        (bound_top_ff),
      .size      (bound_height_ff),
      .vsize     (view_height_ff),
      .gain      (follow_gain_ff),
      .recip     (spring_recip_ff),
      .pos       (pos_y),
      .aim_dist  (dist_y)
   );

   // The reached flag is sticky; attach clears it and a close tick sets it.
   assign dist_sum = {1'b0, dist_x} + {1'b0, dist_y};

   always_comb begin
      reached_in = reached_ff;
      if (cmd.attach) begin
         reached_in = 1'b0;
      end
      if (cmd.reach && (dist_sum < REACH_LIMIT)) begin
         reached_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff <= 1'b0;
      end else begin
         reached_ff <= reached_in;
      end
   end

   // Result register, loaded when the controller publishes a result.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         view_x_ff      <= pos_x;
         view_y_ff      <= pos_y;
         rsp_reached_ff <= reached_ff;
      end
   end

   assign rsp_view_x  = view_x_ff;
   assign rsp_view_y  = view_y_ff;
   assign rsp_reached = rsp_reached_ff;

endmodule

// ----- sv/vfsc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences each item through the datapath and owns the request
// and result handshakes. Depends on vfsc_pkg.
module vfsc_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [vfsc_pkg::OPCODE_W-1:0]      req_opcode,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  vfsc_pkg::vfsc_status_type          status,
   output vfsc_pkg::vfsc_cmd_type             cmd
);
   import vfsc_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE       = 11'b000_0000_0001,
      S_AIM_HI     = 11'b000_0000_0010,
      S_AIM_LO     = 11'b000_0000_0100,
      S_ERR        = 11'b000_0000_1000,
      S_MUL_STEP   = 11'b000_0001_0000,
      S_FORCE      = 11'b000_0010_0000,
      S_MUL_SPRING = 11'b000_0100_0000,
      S_MOVE       = 11'b000_1000_0000,
      S_CLAMP      = 11'b001_0000_0000,
      S_REACH      = 11'b010_0000_0000,
      S_PUBLISH    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Item sequencing; ticks skip the spring steps while the filter is off.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PUBLISH;
               unique case (req_opcode)
                  OP_TICK: begin
                     state_in = S_AIM_HI;
                  end
                  OP_FOLLOW: begin
                     cmd.load_aim = 1'b1;
                     state_in     = S_AIM_HI;
                  end
                  OP_ATTACH: begin
                     cmd.attach = 1'b1;
                  end
                  OP_RECENTRE: begin
                     cmd.load_aim = 1'b1;
                  end
                  OP_JUMP: begin
                     cmd.load_aim = 1'b1;
                     cmd.jump     = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_AIM_HI: begin
            cmd.aim_hi = 1'b1;
            state_in   = S_AIM_LO;
         end
         S_AIM_LO: begin
            cmd.aim_lo = 1'b1;
            state_in   = S_ERR;
         end
         S_ERR: begin
            cmd.err  = 1'b1;
            state_in = S_MUL_STEP;
         end
         S_MUL_STEP: begin
            cmd.mul_step = 1'b1;
            state_in     = status.spring_on ? S_FORCE : S_MOVE;
         end
         S_FORCE: begin
            cmd.force_sum = 1'b1;
            state_in      = S_MUL_SPRING;
         end
         S_MUL_SPRING: begin
            cmd.mul_spring = 1'b1;
            state_in       = S_MOVE;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_REACH;
         end
         S_REACH: begin
            cmd.reach = 1'b1;
            state_in  = S_PUBLISH;
         end
         S_PUBLISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The result stays valid until its transfer completes.
   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A tick or follow opcode always starts the arithmetic sequence.
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_opcode == OP_TICK) || (req_opcode == OP_FOLLOW))
      |=> (state_ff == S_AIM_HI))
      else $error("tick transfer did not start the aim clamp");

   // Every other opcode goes straight to publishing its result.
   a_other_publishes: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode != OP_TICK) && (req_opcode != OP_FOLLOW)
      |=> (state_ff == S_PUBLISH))
      else $error("non-tick transfer did not go to publish");

   // A published result is offered on the next cycle.
   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not offered");

   // A pending result is never overwritten by the next one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUBLISH) && rsp_valid_ff && !rsp_ready
      |=> (state_ff == S_PUBLISH))
      else $error("result overwritten while still pending");

endmodule

// ----- sv/viewport_follow_spring_clamp_unit.sv -----
`timescale 1ns / 1ps
// Viewport follow unit with bounds clamp and spring filter.
// A tick or follow runs the aim clamp, error, step product, force sum and spring
// product (spring filter on only), move, clamp, reach and publish steps; the other
// opcodes go straight to publish. New requests wait until the result is published.
// Synchronous active-high reset clears the view, aim, force and reached flag and
// loads the register defaults; no clearing pass is needed. Depends on vfsc_pkg.
module viewport_follow_spring_clamp_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vfsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vfsc_pkg::COORD_W-1:0]         csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [vfsc_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [vfsc_pkg::COORD_W-1:0]  req_target_x,
   input  logic signed [vfsc_pkg::COORD_W-1:0]  req_target_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [vfsc_pkg::COORD_W-1:0]  rsp_view_x,
   output logic signed [vfsc_pkg::COORD_W-1:0]  rsp_view_y,
   output logic                                 rsp_reached
);
   import vfsc_pkg::*;

   vfsc_cmd_type    cmd;
   vfsc_status_type status;
   logic            csr_write;

   // Register writes are taken in any cycle.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   vfsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   vfsc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .cmd          (cmd),
      .status       (status),
      .rsp_view_x   (rsp_view_x),
      .rsp_view_y   (rsp_view_y),
      .rsp_reached  (rsp_reached)
   );

endmodule

// ----- tb/sv/tb_viewport_follow_spring_clamp_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for viewport_follow_spring_clamp_unit: directed table, then
// random follow sequences under several register settings. Depends on vfsc_pkg and the unit.
module tb_viewport_follow_spring_clamp_unit;
   import vfsc_pkg::*;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      reached;
   } view_result_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]       op;
      logic signed [COORD_W-1:0] tx;
      logic signed [COORD_W-1:0] ty;
      logic                      typed;
      view_result_type           want;
   } directed_row_type;

   localparam logic [OPCODE_W-1:0] OP_RESERVED_5 = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_RESERVED_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_RESERVED_7 = 3'd7;
   localparam logic signed [COORD_W-1:0] MAX_COORD = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] MIN_COORD = 32'sh8000_0000;
   localparam longint LIM_HI = longint'(MAX_COORD);
   localparam longint LIM_LO = longint'(MIN_COORD);
   localparam view_result_type NO_VIEW = '0;
   localparam int SETTLE_CYCLES = 14;
   localparam int DIRECTED_ROWS = 19;
   localparam int PHASES = 10;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [COORD_W-1:0]        csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OPCODE_W-1:0]       req_opcode = '0;
   logic signed [COORD_W-1:0] req_target_x = '0;
   logic signed [COORD_W-1:0] req_target_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_view_x;
   logic signed [COORD_W-1:0] rsp_view_y;
   logic                      rsp_reached;

   // Expected view results, oldest first.
   view_result_type pending_views[$];
   int              mismatch_count = 0;
   bit              quiet_phase = 1'b0;

   // Shadow copy of the registers and of the follow state.
   longint cfg_left, cfg_top, cfg_bw, cfg_bh, cfg_vw, cfg_vh, cfg_gain, cfg_recip;
   longint org_x, org_y, aim_cx, aim_cy, spring_fx, spring_fy;
   bit     reached_seen;

   viewport_follow_spring_clamp_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_view_x   (rsp_view_x),
      .rsp_view_y   (rsp_view_y),
      .rsp_reached  (rsp_reached)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("MISMATCH at %0t ns: %s", $time, msg);
      end
   endtask

   // Arithmetic helpers of the follow model, all exact in 64 bits.
   function automatic longint clip_coord(input longint v);
      if (v > LIM_HI) return LIM_HI;
      if (v < LIM_LO) return LIM_LO;
      return v;
   endfunction

   // Product with a Q0.16 gain, rounded to nearest with ties upward.
   function automatic longint round_q16(input longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Aim centre kept inside the area, or centred there when the view is wider.
   function automatic longint fit_aim(input longint t, input longint lo, input longint size,
                                      input longint half, input longint vsize);
      longint hi;
      hi = lo + size;
      if (t + half > hi) t = hi - half;
      if (t - half < lo) t = lo + half;
      if (vsize > size) t = lo + (size >>> 1);
      return t;
   endfunction

   // Origin clamp, only where the view is strictly smaller than the area.
   function automatic longint fit_origin(input longint p, input longint lo, input longint size,
                                         input longint vsize);
      if (vsize < size) begin
         if (p < lo) p = lo;
         if (p + vsize > lo + size) p = lo + size - vsize;
      end
      return p;
   endfunction

   // One axis of motion: proportional, or through the spring with its deadband.
   function automatic void step_axis(inout longint org, inout longint frc, input longint aim,
                                     input longint half);
      longint motion, nf;
      motion = round_q16((aim - org - half) * cfg_gain);
      if (cfg_recip != 0) begin
         nf = clip_coord(frc + motion);
         nf = round_q16(nf * cfg_recip);
         if (magnitude(nf) < FORCE_DEADBAND) nf = 0;
         frc = nf;
         org = clip_coord(org + nf);
      end else begin
         org = clip_coord(org + motion);
      end
   endfunction

   function automatic void run_tick();
      longint hw, hh;
      bit     bounded;
      hw = cfg_vw >>> 1;
      hh = cfg_vh >>> 1;
      bounded = (cfg_bw + cfg_bh) != 0;
      if (bounded) begin
         aim_cy = clip_coord(fit_aim(aim_cy, cfg_top, cfg_bh, hh, cfg_vh));
         aim_cx = clip_coord(fit_aim(aim_cx, cfg_left, cfg_bw, hw, cfg_vw));
      end
      step_axis(org_x, spring_fx, aim_cx, hw);
      step_axis(org_y, spring_fy, aim_cy, hh);
      if (bounded) begin
         org_x = clip_coord(fit_origin(org_x, cfg_left, cfg_bw, cfg_vw));
         org_y = clip_coord(fit_origin(org_y, cfg_top, cfg_bh, cfg_vh));
      end
      if (magnitude(org_x - aim_cx + hw) + magnitude(org_y - aim_cy + hh)
          < (longint'(REACH_DIST) << FRAC_BITS)) begin
         reached_seen = 1'b1;
      end
   endfunction

   // Applies one request to the shadow state and returns the view it should produce.
   function automatic view_result_type advance_view(input logic [OPCODE_W-1:0] op,
                                                    input logic signed [COORD_W-1:0] tx,
                                                    input logic signed [COORD_W-1:0] ty);
      view_result_type res;
      case (op)
         OP_TICK: begin
            run_tick();
         end
         OP_FOLLOW: begin
            aim_cx = tx;
            aim_cy = ty;
            run_tick();
         end
         OP_ATTACH: begin
            reached_seen = 1'b0;
         end
         OP_RECENTRE: begin
            aim_cx = tx;
            aim_cy = ty;
         end
         OP_JUMP: begin
            aim_cx = tx;
            aim_cy = ty;
            org_x = clip_coord(aim_cx - (cfg_vw >>> 1));
            org_y = clip_coord(aim_cy - (cfg_vh >>> 1));
            spring_fx = 0;
            spring_fy = 0;
         end
         default: begin
         end
      endcase
      res.x = org_x[COORD_W-1:0];
      res.y = org_y[COORD_W-1:0];
      res.reached = reached_seen;
      return res;
   endfunction

   function automatic int pick_idle_len();
      int unsigned r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Target centre: mostly inside the area or near the current aim, sometimes anywhere.
   function automatic logic signed [COORD_W-1:0] pick_target(input longint lo,
                                                             input longint span,
                                                             input longint near);
      int unsigned r;
      longint      v;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         v = lo - 16384 + longint'($urandom_range(0, 32'(span + 32768)));
      end else if (r < 80) begin
         v = near - 4096 + longint'($urandom_range(0, 8192));
      end else if (r < 92) begin
         v = longint'($signed($urandom()));
      end else begin
         case ($urandom_range(0, 3))
            0: v = LIM_HI;
            1: v = LIM_LO;
            2: v = 0;
            default: v = -1;
         endcase
      end
      return COORD_W'(clip_coord(v));
   endfunction

   // Request transfer; valid is lowered only when a gap follows.
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic signed [COORD_W-1:0] tx,
                            input logic signed [COORD_W-1:0] ty, input logic typed,
                            input view_result_type want);
      view_result_type predicted;
      int              gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_target_x <= tx;
      req_target_y <= ty;
      do @(posedge clock); while (!req_ready);
      predicted = advance_view(op, tx, ty);
      pending_views.push_back(typed ? want : predicted);
      gap = pick_idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [COORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_BOUND_LEFT:   cfg_left = longint'($signed(data));
         CSR_BOUND_TOP:    cfg_top = longint'($signed(data));
         CSR_BOUND_WIDTH:  cfg_bw = longint'(data[SIZE_W-1:0]);
         CSR_BOUND_HEIGHT: cfg_bh = longint'(data[SIZE_W-1:0]);
         CSR_VIEW_WIDTH:   cfg_vw = longint'(data[SIZE_W-1:0]);
         CSR_VIEW_HEIGHT:  cfg_vh = longint'(data[SIZE_W-1:0]);
         CSR_FOLLOW_GAIN:  cfg_gain = longint'(data[GAIN_W-1:0]);
         CSR_SPRING_RECIP: cfg_recip = longint'(data[GAIN_W-1:0]);
         default: begin
         end
      endcase
   endtask

   // Writes every register; unused upper bits of narrow registers carry random junk.
   task automatic write_config(input logic [COORD_W-1:0] left, input logic [COORD_W-1:0] top,
                               input logic [SIZE_W-1:0] bw, input logic [SIZE_W-1:0] bh,
                               input logic [SIZE_W-1:0] vw, input logic [SIZE_W-1:0] vh,
                               input logic [GAIN_W-1:0] gain, input logic [GAIN_W-1:0] recip);
      write_csr(CSR_BOUND_LEFT, left);
      write_csr(CSR_BOUND_TOP, top);
      write_csr(CSR_BOUND_WIDTH, {1'($urandom()), bw});
      write_csr(CSR_BOUND_HEIGHT, {1'($urandom()), bh});
      write_csr(CSR_VIEW_WIDTH, {1'($urandom()), vw});
      write_csr(CSR_VIEW_HEIGHT, {1'($urandom()), vh});
      write_csr(CSR_FOLLOW_GAIN, {16'($urandom()), gain});
      write_csr(CSR_SPRING_RECIP, {16'($urandom()), recip});
      csr_valid <= 1'b0;
   endtask

   task automatic wait_until_idle();
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Main stimulus: reset, directed table, then one random stretch per register setting.
   initial begin
      directed_row_type directed_rows [DIRECTED_ROWS];
      int               phase;
      int               counted;
      int               quota;
      int               ticks;
      logic [OPCODE_W-1:0] op;

      directed_rows = '{
         '{OP_ATTACH, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
         '{OP_RESERVED_5, -32'sd1, -32'sd1, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
         '{OP_RESERVED_7, MIN_COORD, MAX_COORD, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
         '{OP_TICK, 32'sd0, 32'sd0, 1'b0, NO_VIEW},
         '{OP_JUMP, MAX_COORD, MAX_COORD, 1'b1, '{32'sh7FFE_BFFF, 32'sh7FFF_0FFF, 1'b0}},
         '{OP_JUMP, MIN_COORD, MIN_COORD, 1'b1, '{MIN_COORD, MIN_COORD, 1'b0}},
         '{OP_FOLLOW, MAX_COORD, MIN_COORD, 1'b0, NO_VIEW},
         '{OP_RECENTRE, 32'sd81920, 32'sd61440, 1'b0, NO_VIEW},
         '{OP_JUMP, 32'sd81920, 32'sd61440, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
         '{OP_TICK, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 1'b1}},
         '{OP_TICK, -32'sd1, 32'sd5, 1'b1, '{32'sd0, 32'sd0, 1'b1}},
         '{OP_ATTACH, 32'sd9, -32'sd9, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
         '{OP_FOLLOW, 32'sd12800, -32'sd12800, 1'b0, NO_VIEW},
         '{OP_TICK, 32'sd0, 32'sd0, 1'b0, NO_VIEW},
         '{OP_RESERVED_6, 32'sd77, 32'sd77, 1'b0, NO_VIEW},
         '{OP_FOLLOW, MIN_COORD, MAX_COORD, 1'b0, NO_VIEW},
         '{OP_TICK, 32'sd0, 32'sd0, 1'b0, NO_VIEW},
         '{OP_RECENTRE, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, NO_VIEW},
         '{OP_TICK, 32'sd0, 32'sd0, 1'b0, NO_VIEW}
      };

      cfg_left = 0;
      cfg_top = 0;
      cfg_bw = 0;
      cfg_bh = 0;
      cfg_vw = longint'(VIEW_WIDTH_RESET);
      cfg_vh = longint'(VIEW_HEIGHT_RESET);
      cfg_gain = longint'(FOLLOW_GAIN_RESET);
      cfg_recip = 0;
      org_x = 0;
      org_y = 0;
      aim_cx = 0;
      aim_cy = 0;
      spring_fx = 0;
      spring_fy = 0;
      reached_seen = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(directed_rows[i].op, directed_rows[i].tx, directed_rows[i].ty,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         quota = (phase == 0) ? 150 : 180;
         // Register settings are changed only once the unit has gone idle.
         if (phase != 0) begin
            req_valid <= 1'b0;
            wait_until_idle();
            case (phase)
               1: write_config(MIN_COORD, MIN_COORD, '1, '1, 31'd1, 31'd1, '1, '1);
               2: write_config(MAX_COORD, MAX_COORD, '1, 31'd0, '1, '1, 16'd0, 16'd0);
               3: write_config($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               31'd0, 31'd0,
                               31'($urandom_range(32'h1000, 32'h4_0000)),
                               31'($urandom_range(32'h1000, 32'h4_0000)),
                               16'($urandom_range(2000, 30000)),
                               16'($urandom_range(1000, 60000)));
               4: write_config($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               31'($urandom_range(32'h8_0000, 32'h40_0000)),
                               31'($urandom_range(32'h8_0000, 32'h40_0000)),
                               31'($urandom_range(32'h1000, 32'h4_0000)),
                               31'($urandom_range(32'h1000, 32'h4_0000)),
                               16'($urandom_range(1000, 40000)), 16'd0);
               5: write_config($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               31'($urandom_range(32'h4000, 32'h2_0000)),
                               31'($urandom_range(32'h8_0000, 32'h40_0000)),
                               31'($urandom_range(32'h4_0000, 32'h10_0000)),
                               31'($urandom_range(32'h1000, 32'h4_0000)),
                               16'($urandom_range(2000, 30000)),
                               16'($urandom_range(1000, 60000)));
               6: write_config($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               31'($urandom_range(32'h8_0000, 32'h40_0000)),
                               31'($urandom_range(32'h8_0000, 32'h40_0000)),
                               31'd0, 31'd0,
                               16'($urandom_range(2000, 30000)),
                               16'($urandom_range(1000, 60000)));
               7: write_config($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                               31'($urandom_range(32'h8_0000, 32'h40_0000)),
                               31'($urandom_range(32'h8_0000, 32'h40_0000)),
                               31'($urandom_range(32'h1000, 32'h4_0000)),
                               31'($urandom_range(32'h1000, 32'h4_0000)),
                               16'($urandom_range(200, 3000)),
                               16'($urandom_range(50, 2000)));
               8: write_config($urandom(), $urandom(), 31'($urandom()), 31'($urandom()),
                               31'($urandom()), 31'($urandom()), 16'($urandom()),
                               16'($urandom()));
               default: write_config(32'd0, 32'd0, 31'h10_0000, 31'd0, VIEW_WIDTH_RESET,
                                     VIEW_HEIGHT_RESET, FOLLOW_GAIN_RESET, 16'd0);
            endcase
            @(posedge clock);
         end
         quiet_phase = (phase == 3) || (phase == 7);

         // Mostly well-formed runs: a new aim followed by a burst of ticks.
         counted = 0;
         while (counted < quota) begin
            if ($urandom_range(0, 99) < 80) begin
               case ($urandom_range(0, 3))
                  0, 1: op = OP_FOLLOW;
                  2: op = OP_JUMP;
                  default: op = OP_RECENTRE;
               endcase
               send_item(op, pick_target(cfg_left, cfg_bw, aim_cx),
                         pick_target(cfg_top, cfg_bh, aim_cy), 1'b0, NO_VIEW);
               counted++;
               ticks = $urandom_range(1, 40);
               repeat (ticks) begin
                  op = ($urandom_range(0, 29) == 0) ? OP_ATTACH : OP_TICK;
                  send_item(op, $urandom(), $urandom(), 1'b0, NO_VIEW);
                  counted++;
               end
            end else begin
               op = OPCODE_W'($urandom_range(0, 7));
               send_item(op, pick_target(cfg_left, cfg_bw, aim_cx),
                         pick_target(cfg_top, cfg_bh, aim_cy), 1'b0, NO_VIEW);
               if (op <= OP_JUMP) counted++;
            end
         end
      end

      req_valid <= 1'b0;
      quiet_phase = 1'b0;
      wait_until_idle();
      if (pending_views.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_views.size()));
      end
      if (mismatch_count == 0) begin
         $display("viewport_follow_spring_clamp_unit test passed");
      end else begin
         $display("viewport_follow_spring_clamp_unit test failed");
      end
      $finish;
   end

   // Result side: compare each transfer with the oldest expectation, stall at random.
   initial begin
      view_result_type got;
      view_result_type want;
      int              stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_view_x, rsp_view_y, rsp_reached};
            if (pending_views.size() == 0) begin
               report_mismatch($sformatf("unexpected result x=%0d y=%0d reached=%0b",
                                         got.x, got.y, got.reached));
            end else begin
               want = pending_views.pop_front();
               if (got.x !== want.x) begin
                  report_mismatch($sformatf("view_x %0d, expected %0d", got.x, want.x));
               end
               if (got.y !== want.y) begin
                  report_mismatch($sformatf("view_y %0d, expected %0d", got.y, want.y));
               end
               if (got.reached !== want.reached) begin
                  report_mismatch($sformatf("reached %0b, expected %0b",
                                            got.reached, want.reached));
               end
            end
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_idle_len();
         end
      end
   end

   // Hard limit on the run.
   initial begin
      #10_000_000;
      $display("viewport_follow_spring_clamp_unit test failed");
      $finish;
   end

endmodule
